[src/wsfu_pkg.sv]
`default_nettype none
package wsfu_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       chunk_start;
	} wsfu_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last_of_frame;
	} wsfu_out_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_KEY     = 3'd2,
		PH_PAYLOAD = 3'd3,
		PH_DROP    = 3'd4
	} wsfu_phase_t;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_BAD   = 2'd2;

	localparam logic [3:0] MAX_OPCODE = 4'd2;

endpackage
`default_nettype wire

[src/wsfu_parser.sv]
`default_nettype none
module wsfu_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire wsfu_pkg::wsfu_in_t  item,
	output wsfu_pkg::wsfu_out_t    res,
	output logic                   res_valid
);
	import wsfu_pkg::*;

	wsfu_phase_t phase_q, phase_n, ph;
	logic [6:0]  len_q, len_n;
	logic [31:0] key_q, key_n;
	logic        masked_q, masked_n;
	logic [1:0]  kidx_q, kidx_n;
	logic [7:0]  b;
	logic [7:0]  key_byte;

	assign b        = item.in_byte;
	assign key_byte = key_q[{kidx_q, 3'b000} +: 8];

	always_comb begin
		ph        = item.chunk_start ? PH_HEADER : phase_q;
		phase_n   = ph;
		len_n     = len_q;
		key_n     = key_q;
		masked_n  = masked_q;
		kidx_n    = kidx_q;
		res       = '0;
		res_valid = 1'b0;
		case (ph)
			PH_LENGTH: begin
				masked_n = b[7];
				len_n    = b[6:0];
				kidx_n   = 2'd0;
				if (b[7]) begin
					phase_n = PH_KEY;
				end else if (b[6:0] == 7'd0) begin
					phase_n           = PH_HEADER;
					res.kind          = KIND_EMPTY;
					res.last_of_frame = 1'b1;
					res_valid         = 1'b1;
				end else begin
					phase_n = PH_PAYLOAD;
				end
			end
			PH_KEY: begin
				key_n[{kidx_q, 3'b000} +: 8] = b;
				kidx_n = kidx_q + 2'd1;
				// all four key bytes in
				if (kidx_q == 2'd3) begin
					if (len_q == 7'd0) begin
						phase_n           = PH_HEADER;
						res.kind          = KIND_EMPTY;
						res.last_of_frame = 1'b1;
						res_valid         = 1'b1;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res.out_byte      = masked_q ? (b ^ key_byte) : b;
				res.kind          = KIND_DATA;
				kidx_n            = kidx_q + 2'd1;
				len_n             = len_q - 7'd1;
				res.last_of_frame = (len_n == 7'd0);
				res_valid         = 1'b1;
				if (len_n == 7'd0) begin
					phase_n = PH_HEADER;
				end
			end
			PH_DROP: begin
				phase_n = PH_DROP;
			end
			default: begin
				if (b[3:0] > MAX_OPCODE) begin
					phase_n   = PH_DROP;
					res.kind  = KIND_BAD;
					res_valid = 1'b1;
				end else begin
					phase_n = PH_LENGTH;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			len_q    <= '0;
			key_q    <= '0;
			masked_q <= 1'b0;
			kidx_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_n;
			len_q    <= len_n;
			key_q    <= key_n;
			masked_q <= masked_n;
			kidx_q   <= kidx_n;
		end
	end

endmodule
`default_nettype wire

[src/websocket_frame_unmasker_top.sv]
// WebSocket frame deframer / unmasker.
// Input channel (in_valid/in_ready/in_data): one stream byte per transfer, with
// chunk_start marking the first byte of a received chunk (parsing restarts there).
// Output channel (out_valid/out_ready/out_data): at most one result per input
// byte: an unmasked payload byte, an empty-frame marker, or a bad-opcode marker.
// Header, length and key bytes produce no result but the markers; after a bad opcode
// all bytes are swallowed until the next chunk start.
// A result passes through the input register, then the parse step into the
// output register, and transfers from there.
// Throughput: one byte per cycle while results are taken; the parse step is
// combinational compare/XOR logic on the frame state.
// When the receiver stalls, the output register holds its result and the input
// register holds one more byte; bytes that yield no result keep flowing.
// Reset: pipeline empty, parser expects a header byte, mask key cleared.
`default_nettype none
module websocket_frame_unmasker_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire wsfu_pkg::wsfu_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output wsfu_pkg::wsfu_out_t      out_data
);
	import wsfu_pkg::*;

	wsfu_in_t  item_s1;
	logic      valid_s1;
	wsfu_out_t res;
	logic      res_valid;
	wsfu_out_t out_q;
	logic      out_valid_q;
	logic      out_free;
	logic      advance;

	assign out_free  = !out_valid_q || out_ready;
	// a byte with no result never waits on the output register
	assign advance   = valid_s1 && (out_free || !res_valid);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	wsfu_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res       (res),
		.res_valid (res_valid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res_valid) begin
			out_q <= res;
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost or changed a stalled byte");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("pending result overwritten");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.kind == KIND_DATA || out_q.kind == KIND_EMPTY
			|| out_q.kind == KIND_BAD))
		else $error("illegal result kind");

	a_marker_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind != KIND_DATA |-> out_q.out_byte == 8'd0
			&& out_q.last_of_frame == (out_q.kind == KIND_EMPTY))
		else $error("marker result carries bad fields");

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

import wsfu_pkg::*;

class frame_unmask_scoreboard;
	wsfu_phase_t parse_phase;
	logic [6:0]  bytes_left;
	logic [31:0] mask_key;
	logic        masked;
	logic [1:0]  key_idx;
	wsfu_out_t   frame_results[$];
	int          mismatches;

	function new();
		parse_phase = PH_HEADER;
		bytes_left  = '0;
		mask_key    = '0;
		masked      = 1'b0;
		key_idx     = '0;
		mismatches  = 0;
	endfunction

	// Advance the parser by one accepted byte and queue its result, if any.
	function void take_byte(wsfu_in_t item);
		logic [7:0] b;
		wsfu_out_t  res;
		bit         emits;
		b     = item.in_byte;
		res   = '0;
		emits = 1'b0;
		if (item.chunk_start)
			parse_phase = PH_HEADER;
		case (parse_phase)
			PH_LENGTH: begin
				masked     = b[7];
				bytes_left = b[6:0];
				key_idx    = '0;
				if (masked) begin
					parse_phase = PH_KEY;
				end else if (bytes_left == 0) begin
					parse_phase       = PH_HEADER;
					res.kind          = KIND_EMPTY;
					res.last_of_frame = 1'b1;
					emits             = 1'b1;
				end else begin
					parse_phase = PH_PAYLOAD;
				end
			end
			PH_KEY: begin
				mask_key[{key_idx, 3'b000} +: 8] = b;
				key_idx = key_idx + 2'd1;
				if (key_idx == 0) begin
					if (bytes_left == 0) begin
						parse_phase       = PH_HEADER;
						res.kind          = KIND_EMPTY;
						res.last_of_frame = 1'b1;
						emits             = 1'b1;
					end else begin
						parse_phase = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				res.out_byte      = masked ? (b ^ mask_key[{key_idx, 3'b000} +: 8]) : b;
				key_idx           = key_idx + 2'd1;
				bytes_left        = bytes_left - 7'd1;
				res.kind          = KIND_DATA;
				res.last_of_frame = (bytes_left == 0);
				if (bytes_left == 0)
					parse_phase = PH_HEADER;
				emits = 1'b1;
			end
			PH_DROP: begin
			end
			default: begin
				if (b[3:0] > MAX_OPCODE) begin
					parse_phase = PH_DROP;
					res.kind    = KIND_BAD;
					emits       = 1'b1;
				end else begin
					parse_phase = PH_LENGTH;
				end
			end
		endcase
		if (emits)
			frame_results.push_back(res);
	endfunction

	function void compare_result(wsfu_out_t got);
		wsfu_out_t want;
		if (frame_results.size() == 0) begin
			if (mismatches < 10)
				$display("%0t: result with nothing pending: byte %02h kind %0d last %0b",
					$realtime, got.out_byte, got.kind, got.last_of_frame);
			mismatches++;
			return;
		end
		want = frame_results.pop_front();
		if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
				got.last_of_frame !== want.last_of_frame) begin
			if (mismatches < 10)
				$display("%0t: mismatch: want %02h/%0d/%0b, got %02h/%0d/%0b",
					$realtime, want.out_byte, want.kind, want.last_of_frame,
					got.out_byte, got.kind, got.last_of_frame);
			mismatches++;
		end
	endfunction
endclass

module tb;
	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	wsfu_in_t  in_data   = '0;
	logic      out_ready = 1'b0;
	logic      in_ready;
	logic      out_valid;
	wsfu_out_t out_data;

	frame_unmask_scoreboard sb = new();
	wsfu_in_t frame_bytes[$];
	bit       idle_enable = 1'b1;
	bit       force_start = 1'b1;
	int       bytes_sent  = 0;

	websocket_frame_unmasker_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// transfer monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.take_byte(in_data);
			if (out_valid && out_ready)
				sb.compare_result(out_data);
		end
	end

	// receiver with random stall bursts
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (idle_enable && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic void add_byte(logic [7:0] b, logic start);
		wsfu_in_t item;
		item.in_byte     = b;
		item.chunk_start = start;
		frame_bytes.push_back(item);
	endfunction

	task automatic send_byte(input wsfu_in_t item, input bit counted);
		if (idle_enable && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		if (counted)
			bytes_sent++;
	endtask

	task automatic send_frame_bytes();
		while (frame_bytes.size() != 0)
			send_byte(frame_bytes.pop_front(), 1'b1);
	endtask

	// Well-formed frame with random content, optionally cut short by the next chunk start.
	task automatic gen_frame(input bit cut);
		int  len;
		int  pick;
		bit  is_masked;
		int  cut_at;
		pick      = $urandom_range(0, 99);
		is_masked = $urandom_range(0, 1);
		if (pick < 2)
			len = $urandom_range(126, 127);
		else if (pick < 5)
			len = $urandom_range(13, 125);
		else
			len = $urandom_range(0, 12);
		add_byte({4'($urandom_range(0, 15)), 4'($urandom_range(0, MAX_OPCODE))},
			force_start || $urandom_range(0, 2) == 0);
		add_byte({is_masked, 7'(len)}, 1'b0);
		if (is_masked)
			repeat (4) add_byte(8'($urandom), 1'b0);
		repeat (len) add_byte(8'($urandom), 1'b0);
		if (cut) begin
			cut_at = $urandom_range(1, frame_bytes.size() - 1);
			while (frame_bytes.size() > cut_at)
				void'(frame_bytes.pop_back());
		end
		force_start = cut;
		send_frame_bytes();
	endtask

	task automatic gen_bad_opcode();
		wsfu_in_t item;
		item.in_byte     = {4'($urandom_range(0, 15)), 4'($urandom_range(MAX_OPCODE + 1, 15))};
		item.chunk_start = force_start || $urandom_range(0, 1);
		send_byte(item, 1'b1);
		// swallowed until the next chunk start
		repeat ($urandom_range(0, 8)) begin
			item.in_byte     = 8'($urandom);
			item.chunk_start = 1'b0;
			send_byte(item, 1'b0);
		end
		force_start = 1'b1;
	endtask

	task automatic gen_noise();
		repeat ($urandom_range(1, 6))
			add_byte(8'($urandom), 1'($urandom_range(0, 1)));
		send_frame_bytes();
		force_start = 1'b1;
	endtask

	initial begin
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unmasked empty frame
		add_byte(8'h81, 1'b1);
		add_byte(8'h00, 1'b0);
		// masked empty frame, done after the fourth key byte
		add_byte(8'h80, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hA5, 1'b0);
		add_byte(8'h5A, 1'b0);
		// masked three-byte frame, opcode 2 with high nibble set
		add_byte(8'h72, 1'b0);
		add_byte(8'h83, 1'b0);
		add_byte(8'h12, 1'b0);
		add_byte(8'h34, 1'b0);
		add_byte(8'h56, 1'b0);
		add_byte(8'h78, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'hAA, 1'b0);
		// unmasked frame cut off by a chunk start carrying a bad opcode
		add_byte(8'h00, 1'b1);
		add_byte(8'h05, 1'b0);
		add_byte(8'h11, 1'b0);
		add_byte(8'h22, 1'b0);
		add_byte(8'h8F, 1'b1);
		add_byte(8'hFF, 1'b0);
		// lowest bad opcode right at a chunk start
		add_byte(8'h03, 1'b1);
		send_frame_bytes();
		force_start = 1'b1;

		while (bytes_sent < 1100) begin
			idle_enable = (bytes_sent < 950) && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				gen_frame(1'b0);
			else if (pick < 80)
				gen_frame(1'b1);
			else if (pick < 90)
				gen_bad_opcode();
			else
				gen_noise();
		end
		in_valid <= 1'b0;

		while (sb.frame_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule

[sim.f]
src/wsfu_pkg.sv
src/wsfu_parser.sv
src/websocket_frame_unmasker_top.sv
verif/tb.sv
